// ===== rtl/adc_sample_smoothing_filter_macros.svh =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - assertion macros
// Concurrent check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_SAMPLE_SMOOTHING_FILTER_MACROS_SVH
`define ADC_SAMPLE_SMOOTHING_FILTER_MACROS_SVH
`ifndef SYNTH
// property checked on every clock edge outside reset
`define ASSF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// trigger in one cycle implies outcome in the next
`define ASSF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: sequencing check failed");
`else
`define ASSF_ASSERT(lbl, clk, rst_n, prop)
`define ASSF_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/assf_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - package
// Widths, smoothing coefficients and control structs shared by the block.
// ----------------------------------------------------------------------------
package assf_pkg;

    localparam int RING_DEPTH = 11;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int OUT_W      = SAMPLE_W + FRAC_W;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 26;
    localparam int MAG_W      = ACC_W - 1;
    localparam int DIV_W      = 9;
    localparam int QUOT_W     = OUT_W;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 4;
    localparam int DSTEP_W    = 5;
    localparam int FROZEN_MIN = 10;

    localparam logic [DIV_W-1:0] SG_NORM      = DIV_W'(429);
    localparam logic [OUT_W-1:0] OUT_MAX_CODE = 24'h7F_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN_CODE = 24'h80_0000;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_ring_ctl;

    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctl;

    // 11-point quadratic smoothing weights, oldest sample first
    function automatic logic signed [COEF_W-1:0] sg_coef(input logic [STEP_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        begin
            unique case (k)
                4'd0, 4'd10: c = -COEF_W'(36);
                4'd1, 4'd9:  c = COEF_W'(9);
                4'd2, 4'd8:  c = COEF_W'(44);
                4'd3, 4'd7:  c = COEF_W'(69);
                4'd4, 4'd6:  c = COEF_W'(84);
                4'd5:        c = COEF_W'(89);
                default:     c = '0;
            endcase
            return c;
        end
    endfunction

    // tap at step k holds a stored sample once k reaches depth - count
    function automatic logic slot_stored(input logic [STEP_W-1:0] k,
                                         input logic [CNT_W-1:0] cnt);
        logic [STEP_W:0] reach;
        begin
            reach = {1'b0, k} + {1'b0, cnt};
            return (reach >= (STEP_W+1)'(RING_DEPTH));
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] step_coef(input logic [STEP_W-1:0] k,
                                                          input logic smooth,
                                                          input logic [CNT_W-1:0] cnt);
        logic signed [COEF_W-1:0] c;
        begin
            if (smooth) begin
                c = sg_coef(k);
            end else if (slot_stored(k, cnt)) begin
                c = COEF_W'(1);
            end else begin
                c = '0;
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/assf_if.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - channel interfaces
// Valid/ready channels for samples, results and the enable register.
// ----------------------------------------------------------------------------
interface assf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [assf_pkg::SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface assf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [assf_pkg::OUT_W-1:0] filtered_value;
    logic                              used_smoothing;
    logic                              frozen;

    modport source (output valid, output filtered_value, output used_smoothing,
                    output frozen, input ready);
    modport sink   (input valid, input filtered_value, input used_smoothing,
                    input frozen, output ready);
endinterface

interface assf_cfg_if;
    logic valid;
    logic ready;
    logic filter_enable;

    modport source (output valid, output filter_enable, input ready);
    modport sink   (input valid, input filter_enable, output ready);
endinterface

// ===== rtl/assf_ring.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - sample ring
// Shift line of recent samples, newest at the head; rotates for the MAC pass.
// ----------------------------------------------------------------------------
module assf_ring (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  assf_pkg::t_ring_ctl                  i_ctl,
    input  logic signed [assf_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [assf_pkg::SAMPLE_W-1:0] o_tap,
    output logic        [assf_pkg::CNT_W-1:0]    o_count
);
    import assf_pkg::*;

    logic signed [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic        [CNT_W-1:0]    r_count;

    // unfilled taps must read as zero so the masked MAC terms stay clean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_ctl.push) begin
            r_ring[0] <= i_sample;
            for (int i = 1; i < RING_DEPTH; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
        end else if (i_ctl.rotate) begin
            r_ring[0] <= r_ring[RING_DEPTH-1];
            for (int i = 1; i < RING_DEPTH; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.push && (r_count != CNT_W'(RING_DEPTH))) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_tap   = r_ring[RING_DEPTH-1];
    assign o_count = r_count;

endmodule

// ===== rtl/assf_mac.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - multiply-accumulate
// One tap times one coefficient per enabled cycle into a signed accumulator.
// ----------------------------------------------------------------------------
module assf_mac (
    input  logic                                 i_clk,
    input  assf_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [assf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [assf_pkg::COEF_W-1:0]   i_coef,
    output logic signed [assf_pkg::ACC_W-1:0]    o_acc
);
    import assf_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  r_acc;

    assign w_prod = i_sample * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/assf_div.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - bit-serial divider
// Restoring division, one quotient bit per cycle; dividend is mag * 2^8.
// ----------------------------------------------------------------------------
module assf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [assf_pkg::MAG_W-1:0]    i_dividend,
    input  logic [assf_pkg::DIV_W-1:0]    i_divisor,
    output logic [assf_pkg::QUOT_W-1:0]   o_quot,
    output logic                          o_done
);
    import assf_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DSTEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_divisor;
    // dividend bits shift out the top while quotient bits shift in the bottom
    logic [QUOT_W-1:0]  r_shift;

    logic [DIV_W:0]     w_trial;
    logic [DIV_W:0]     w_diff;
    logic               w_ge;
    logic [DIV_W-1:0]   n_rem;

    assign w_trial = {r_rem, r_shift[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient fits QUOT_W bits, so the top bits start below the divisor
            r_rem     <= i_dividend[MAG_W-1 -: DIV_W];
            r_shift   <= {i_dividend[MAG_W-DIV_W-1:0], FRAC_W'(0)};
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[QUOT_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DSTEP_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + DSTEP_W'(1);
            end
        end
    end

    assign o_quot = r_shift;
    assign o_done = r_done;

endmodule

// ===== rtl/adc_sample_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// ADC sample smoothing filter - top level
// Eleven-sample Savitzky-Golay smoother with running mean and stuck detect.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one signed 16-bit ADC code per transaction. o_out returns one
//   result per sample: Q15.8 value, a flag for the smoothing window and a flag
//   for ten or more identical stored samples. i_cfg writes filter_enable and
//   is always ready; write it only while no sample is in flight.
//   Each sample is pushed into an 11-entry shift line, then the line rotates
//   past one multiply-accumulate per cycle. With filtering on, a bit-serial
//   divider then produces one quotient bit per cycle to divide by 429 or by
//   the sample count. A sample passes through the MAC, LOAD, DIV (filtering on
//   only) and DONE states before its result enters the output register and
//   o_out.valid rises.
//   One result register sits at the output: the next sample is accepted while
//   a result waits; a finished result stalls until that register empties.
//   Reset empties the sample history and clears filter_enable.
// ----------------------------------------------------------------------------
`include "adc_sample_smoothing_filter_macros.svh"

module adc_sample_smoothing_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    assf_in_if.sink     i_in,
    assf_out_if.source  o_out,
    assf_cfg_if.sink    i_cfg
);
    import assf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                r_state;
    logic [STEP_W-1:0]         r_step;
    logic signed [SAMPLE_W-1:0] r_newest;
    logic                      r_frozen_ok;
    logic                      r_neg;
    logic                      r_filter_enable;
    logic [OUT_W-1:0]          r_result;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_value;
    logic                      r_out_smooth;
    logic                      r_out_frozen;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_smooth;
    t_ring_ctl                 w_ring_ctl;
    t_mac_ctl                  w_mac_ctl;
    logic signed [SAMPLE_W-1:0] w_tap;
    logic [CNT_W-1:0]          w_count;
    logic signed [COEF_W-1:0]  w_coef;
    logic signed [ACC_W-1:0]   w_acc;
    logic [ACC_W-1:0]          w_acc_mag;
    logic                      w_div_start;
    logic [DIV_W-1:0]          w_divisor;
    logic [QUOT_W-1:0]         w_quot;
    logic                      w_div_done;
    logic [OUT_W-1:0]          w_sat;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_smooth    = r_filter_enable && (w_count == CNT_W'(RING_DEPTH));

    always_comb begin
        w_ring_ctl.push   = w_in_acc;
        w_ring_ctl.rotate = (r_state == ST_MAC);
        w_mac_ctl.clear   = w_in_acc;
        w_mac_ctl.en      = (r_state == ST_MAC);
    end

    assign w_coef      = step_coef(r_step, w_smooth, w_count);
    assign w_acc_mag   = w_acc[ACC_W-1] ? -w_acc : w_acc;
    assign w_div_start = (r_state == ST_LOAD) && r_filter_enable;
    assign w_divisor   = w_smooth ? SG_NORM : DIV_W'(w_count);

    assf_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ring_ctl),
        .i_sample (i_in.raw_sample),
        .o_tap    (w_tap),
        .o_count  (w_count)
    );

    assf_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_sample (w_tap),
        .i_coef   (w_coef),
        .o_acc    (w_acc)
    );

    assf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc_mag[MAG_W-1:0]),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // sign-magnitude quotient back to two's complement, clamped to 24 bits
    always_comb begin
        if (!r_neg) begin
            w_sat = w_quot[QUOT_W-1] ? OUT_MAX_CODE : w_quot;
        end else if (w_quot > OUT_MIN_CODE) begin
            w_sat = OUT_MIN_CODE;
        end else begin
            w_sat = ~w_quot + QUOT_W'(1);
        end
    end

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_step          <= '0;
            r_filter_enable <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_filter_enable <= i_cfg.filter_enable;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_step  <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(RING_DEPTH - 1)) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= r_filter_enable ? ST_DIV : ST_DONE;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_newest    <= i_in.raw_sample;
            r_frozen_ok <= 1'b1;
        end else if ((r_state == ST_MAC) && slot_stored(r_step, w_count)
                     && (w_tap != r_newest)) begin
            r_frozen_ok <= 1'b0;
        end
        if (r_state == ST_LOAD) begin
            r_neg    <= w_acc[ACC_W-1];
            r_result <= {r_newest, FRAC_W'(0)};
        end else if ((r_state == ST_DIV) && w_div_done) begin
            r_result <= w_sat;
        end
        if (w_out_load) begin
            r_out_value  <= r_result;
            r_out_smooth <= w_smooth;
            r_out_frozen <= r_frozen_ok && (w_count >= CNT_W'(FROZEN_MIN));
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_value = r_out_value;
    assign o_out.used_smoothing = r_out_smooth;
    assign o_out.frozen         = r_out_frozen;

    `ASSF_ASSERT_NEXT(a_accept_starts_mac, i_clk, i_rst_n, w_in_acc, r_state == ST_MAC)
    `ASSF_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div_done |-> r_state == ST_DIV)
    `ASSF_ASSERT(a_count_bound, i_clk, i_rst_n, w_count <= CNT_W'(RING_DEPTH))
    `ASSF_ASSERT(a_smooth_needs_full, i_clk, i_rst_n, (o_out.valid && o_out.used_smoothing) |-> w_count == CNT_W'(RING_DEPTH))
    `ASSF_ASSERT(a_frozen_needs_ten, i_clk, i_rst_n, (o_out.valid && o_out.frozen) |-> w_count >= CNT_W'(FROZEN_MIN))

endmodule
